/* rtl/joystick_deadzone_normalizer_macros.svh */
// assertion macros shared by the rtl
`ifndef JOYSTICK_DEADZONE_NORMALIZER_MACROS_SVH
`define JOYSTICK_DEADZONE_NORMALIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define JDN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define JDN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/jdn_pkg.sv */
`timescale 1ns / 1ps

package jdn_pkg;

    localparam int ADC_FULL_SCALE = 4095;

    localparam int RAW_W      = 12;
    localparam int CTR_W      = 12;
    localparam int DZ_W       = 12;
    localparam int CNT_W      = 16;
    localparam int SUM_W      = 28;
    localparam int AXIS_W     = 8;
    localparam int OP_W       = 1;
    localparam int SIDE_W     = 17;
    localparam int USABLE_W   = 18;
    localparam int EXC_W      = 13;
    localparam int NUM_W      = 19;
    localparam int DVD_W      = 28;
    localparam int DIVISOR_W  = 17;
    localparam int Q_W        = 12;
    localparam int DIV_STEPS  = 28;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [SIDE_W-1:0] FULL_SCALE_V = SIDE_W'(ADC_FULL_SCALE);
    localparam logic [CTR_W-1:0]  CENTER_RST   = (ADC_FULL_SCALE / 2 > 4095) ?
                                                 CTR_W'(4095) : CTR_W'(ADC_FULL_SCALE / 2);
    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = CNT_W'(64);
    localparam logic [6:0]        AXIS_MAX     = 7'd127;

    localparam logic [OP_W-1:0] OP_READ = 1'b0;
    localparam logic [OP_W-1:0] OP_CAL  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE     = 1'b0,
        REG_SAMPLE_COUNT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP1,
        ST_PREP2,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           ovf;
        logic           done;
    } div_res_t;

    // clamp quotient to 0..127 and apply the sign of the deflection, or give zero in the dead zone
    function automatic logic [AXIS_W-1:0] axis_value(logic zero, logic neg, div_res_t r);
        logic [6:0]        val;
        logic [AXIS_W-1:0] mag;
        val = (r.ovf || r.quot > Q_W'(AXIS_MAX)) ? AXIS_MAX : r.quot[6:0];
        mag = {1'b0, val};
        if (zero)
        begin
            return '0;
        end
        return neg ? AXIS_W'(-mag) : mag;
    endfunction

endpackage

/* rtl/joystick_deadzone_normalizer.sv */
`timescale 1ns / 1ps

// Joystick dead-zone normalizer. Each input word carries an X and a Y ADC sample and an op
// flag in tuser: a calibration sample adds to running sums and, on the configured count-th
// sample, sets each axis center to the truncated average; a read sample yields one output
// word of two signed deflections in -127..127, zero inside the dead zone. A read passes
// through two setup states, the bit-serial restoring dividers (one per axis, one quotient
// bit per cycle) and a finish state that loads the output register once the previous
// output word is no longer held. The input is ready only in the idle state, so a new
// word is taken only after the last one is through. A calibration sample is done on
// accept, or, when it completes the average, runs the same dividers and then writes the
// centers. A finished word waits in the output register while the next input is accepted.
// deadzone (index 0) and sample_count (index 1) are written through cfg_we; the user must
// write them only while the block is idle, which the block itself does not enforce;
// a sample_count of zero acts as one.
module joystick_deadzone_normalizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [jdn_pkg::IN_DATA_W-1:0]  s_tdata,   // raw_x, raw_y
    input  logic [jdn_pkg::OP_W-1:0]       s_tuser,   // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [jdn_pkg::OUT_DATA_W-1:0] m_tdata,   // axis_x, axis_y
    input  logic                           cfg_we,
    input  logic [jdn_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [jdn_pkg::CFG_DATA_W-1:0] cfg_data
);
    import jdn_pkg::*;

    `include "joystick_deadzone_normalizer_macros.svh"

    state_t state_reg;
    state_t state_next;

    logic [DZ_W-1:0]     deadzone_reg;
    logic [CNT_W-1:0]    sample_count_reg;
    logic [CTR_W-1:0]    center_x_reg;
    logic [CTR_W-1:0]    center_y_reg;
    logic [SUM_W-1:0]    sum_x_reg;
    logic [SUM_W-1:0]    sum_y_reg;
    logic [CNT_W-1:0]    taken_reg;
    logic                cal_reg;
    logic [RAW_W-1:0]    raw_x_reg;
    logic [RAW_W-1:0]    raw_y_reg;
    logic [RAW_W-1:0]    mag_x_reg;
    logic [RAW_W-1:0]    mag_y_reg;
    logic [SIDE_W-1:0]   side_x_reg;
    logic [SIDE_W-1:0]   side_y_reg;
    logic                neg_x_reg;
    logic                neg_y_reg;
    logic                zero_x_reg;
    logic                zero_y_reg;
    logic [AXIS_W-1:0]   axis_x_reg;
    logic [AXIS_W-1:0]   axis_y_reg;
    logic                m_tvalid_reg;

    logic                accept;
    logic                div_start;
    logic                out_load;
    logic                center_load;

    logic [CNT_W-1:0]    cnt_eff;
    logic [CNT_W-1:0]    taken_inc;
    logic                cal_done;
    logic [SUM_W-1:0]    sum_x_inc;
    logic [SUM_W-1:0]    sum_y_inc;
    logic [DIVISOR_W-1:0] cal_n;

    logic [EXC_W-1:0]    delta_x;
    logic [EXC_W-1:0]    delta_y;
    logic [RAW_W-1:0]    mag_x;
    logic [RAW_W-1:0]    mag_y;
    logic [SIDE_W-1:0]   side_x;
    logic [SIDE_W-1:0]   side_y;

    logic [EXC_W-1:0]    exc_x;
    logic [EXC_W-1:0]    exc_y;
    logic [USABLE_W-1:0] usable_x;
    logic [USABLE_W-1:0] usable_y;
    logic                zero_x;
    logic                zero_y;
    logic [NUM_W-1:0]    num_x;
    logic [NUM_W-1:0]    num_y;

    logic [DVD_W-1:0]     dvd_x;
    logic [DVD_W-1:0]     dvd_y;
    logic [DIVISOR_W-1:0] dsr_x;
    logic [DIVISOR_W-1:0] dsr_y;
    div_res_t             res_x;
    div_res_t             res_y;

    // calibration accumulate
    always_comb
    begin
        cnt_eff   = (sample_count_reg == '0) ? CNT_W'(1) : sample_count_reg;
        taken_inc = taken_reg + 1'b1;
        cal_done  = (taken_inc == '0) || (taken_inc >= cnt_eff);
        sum_x_inc = sum_x_reg + SUM_W'(s_tdata[RAW_W-1:0]);
        sum_y_inc = sum_y_reg + SUM_W'(s_tdata[2*RAW_W-1:RAW_W]);
        // a wrapped counter means the full 65536 samples
        cal_n     = (taken_inc == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, taken_inc};
    end

    // first setup cycle: magnitude and the full-scale side toward the deflection
    always_comb
    begin
        delta_x = {1'b0, raw_x_reg} - {1'b0, center_x_reg};
        delta_y = {1'b0, raw_y_reg} - {1'b0, center_y_reg};
        mag_x   = delta_x[EXC_W-1] ? RAW_W'(-delta_x) : delta_x[RAW_W-1:0];
        mag_y   = delta_y[EXC_W-1] ? RAW_W'(-delta_y) : delta_y[RAW_W-1:0];
        side_x  = delta_x[EXC_W-1] ? SIDE_W'(center_x_reg)
                                   : FULL_SCALE_V - SIDE_W'(center_x_reg);
        side_y  = delta_y[EXC_W-1] ? SIDE_W'(center_y_reg)
                                   : FULL_SCALE_V - SIDE_W'(center_y_reg);
    end

    // second setup cycle: dead zone removal, usable range, numerator times 127
    always_comb
    begin
        exc_x    = {1'b0, mag_x_reg} - {1'b0, deadzone_reg};
        exc_y    = {1'b0, mag_y_reg} - {1'b0, deadzone_reg};
        usable_x = {side_x_reg[SIDE_W-1], side_x_reg} - USABLE_W'(deadzone_reg);
        usable_y = {side_y_reg[SIDE_W-1], side_y_reg} - USABLE_W'(deadzone_reg);
        zero_x   = exc_x[EXC_W-1] || (exc_x == '0) || usable_x[USABLE_W-1] || (usable_x == '0);
        zero_y   = exc_y[EXC_W-1] || (exc_y == '0) || usable_y[USABLE_W-1] || (usable_y == '0);
        num_x    = {exc_x[RAW_W-1:0], 7'b0} - NUM_W'(exc_x[RAW_W-1:0]);
        num_y    = {exc_y[RAW_W-1:0], 7'b0} - NUM_W'(exc_y[RAW_W-1:0]);
    end

    always_comb
    begin
        if (state_reg == ST_PREP2)
        begin
            dvd_x = DVD_W'(num_x);
            dvd_y = DVD_W'(num_y);
            dsr_x = usable_x[DIVISOR_W-1:0];
            dsr_y = usable_y[DIVISOR_W-1:0];
        end
        else
        begin
            dvd_x = sum_x_inc;
            dvd_y = sum_y_inc;
            dsr_x = cal_n;
            dsr_y = cal_n;
        end
    end

    jdn_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_x),
        .divisor  (dsr_x),
        .res      (res_x)
    );

    jdn_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd_y),
        .divisor  (dsr_y),
        .res      (res_y)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == OP_READ)
                    begin
                        state_next = ST_PREP1;
                    end
                    else if (cal_done)
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_PREP1:
            begin
                state_next = ST_PREP2;
            end
            ST_PREP2:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (res_x.done)
                begin
                    state_next = cal_reg ? ST_IDLE : ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready    = (state_reg == ST_IDLE);
        accept      = s_tvalid && s_tready;
        div_start   = (accept && (s_tuser == OP_CAL) && cal_done) || (state_reg == ST_PREP2);
        out_load    = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);
        center_load = (state_reg == ST_DIV) && res_x.done && cal_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            deadzone_reg     <= '0;
            sample_count_reg <= SAMPLE_COUNT_RST;
            center_x_reg     <= CENTER_RST;
            center_y_reg     <= CENTER_RST;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            taken_reg        <= '0;
            cal_reg          <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DEADZONE:     deadzone_reg     <= cfg_data[DZ_W-1:0];
                    REG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                    default:          deadzone_reg     <= deadzone_reg;
                endcase
            end
            if (accept)
            begin
                cal_reg <= (s_tuser == OP_CAL);
                if (s_tuser == OP_CAL)
                begin
                    if (cal_done)
                    begin
                        sum_x_reg <= '0;
                        sum_y_reg <= '0;
                        taken_reg <= '0;
                    end
                    else
                    begin
                        sum_x_reg <= sum_x_inc;
                        sum_y_reg <= sum_y_inc;
                        taken_reg <= taken_inc;
                    end
                end
            end
            if (center_load)
            begin
                center_x_reg <= res_x.quot;
                center_y_reg <= res_y.quot;
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_x_reg <= s_tdata[RAW_W-1:0];
            raw_y_reg <= s_tdata[2*RAW_W-1:RAW_W];
        end
        if (state_reg == ST_PREP1)
        begin
            mag_x_reg  <= mag_x;
            mag_y_reg  <= mag_y;
            side_x_reg <= side_x;
            side_y_reg <= side_y;
            neg_x_reg  <= delta_x[EXC_W-1];
            neg_y_reg  <= delta_y[EXC_W-1];
        end
        if (state_reg == ST_PREP2)
        begin
            zero_x_reg <= zero_x;
            zero_y_reg <= zero_y;
        end
        if (out_load)
        begin
            axis_x_reg <= axis_value(zero_x_reg, neg_x_reg, res_x);
            axis_y_reg <= axis_value(zero_y_reg, neg_y_reg, res_y);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {axis_y_reg, axis_x_reg};

    `JDN_ASSERT_IMPL(a_div_lockstep, 1'b1, res_x.done == res_y.done, "axis dividers out of step")
    `JDN_ASSERT_NEXT(a_cal_no_word, accept && (s_tuser == OP_CAL), !$rose(m_tvalid), "calibration produced a word")
    `JDN_ASSERT_IMPL(a_word_from_fin, $rose(m_tvalid), $past(state_reg) == ST_FIN, "word not from finish state")
    `JDN_ASSERT_NEXT(a_cal_clear, accept && (s_tuser == OP_CAL) && cal_done, (taken_reg == '0) && (sum_x_reg == '0), "sums not cleared after average")

endmodule

/* rtl/jdn_div.sv */
`timescale 1ns / 1ps

module jdn_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [jdn_pkg::DVD_W-1:0]     dividend,
    input  logic [jdn_pkg::DIVISOR_W-1:0] divisor,
    output jdn_pkg::div_res_t             res
);
    import jdn_pkg::*;

    logic [DVD_W-1:0]     dvd_reg;
    logic [DIVISOR_W-1:0] dsr_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] rem_next;
    logic [Q_W-1:0]       q_reg;
    logic                 ovf_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        diff     = trial - {1'b0, dsr_reg};
        fits     = trial >= {1'b0, dsr_reg};
        rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next;
            // only the low quotient bits are kept, anything above is sticky
            q_reg   <= {q_reg[Q_W-2:0], fits};
            ovf_reg <= ovf_reg | q_reg[Q_W-1];
        end
    end

    assign res.quot = q_reg;
    assign res.ovf  = ovf_reg;
    assign res.done = done_reg;

endmodule

/* sim/joystick_deadzone_normalizer_checker.sv */
`timescale 1ns / 1ps

module joystick_deadzone_normalizer_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [jdn_pkg::IN_DATA_W-1:0]  s_tdata,   // raw_x, raw_y
    input  logic [jdn_pkg::OP_W-1:0]       s_tuser,   // op
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [jdn_pkg::OUT_DATA_W-1:0] m_tdata,   // axis_x, axis_y
    input  logic                           cfg_we,
    input  jdn_pkg::cfg_reg_t              cfg_index,
    input  logic [jdn_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             errors,
    output int                             outstanding,
    output int                             reads_seen,
    output int                             cals_seen,
    output int                             centers_set
);
    import jdn_pkg::*;

    typedef struct {
        logic [AXIS_W-1:0] ax;
        logic [AXIS_W-1:0] ay;
        int                tag;
    } deflection_t;

    deflection_t deflections_due[$];
    deflection_t want;

    logic [DZ_W-1:0]  dz_now;
    logic [CNT_W-1:0] count_now;
    logic [CTR_W-1:0] ctr_x;
    logic [CTR_W-1:0] ctr_y;
    logic [SUM_W-1:0] acc_x;
    logic [SUM_W-1:0] acc_y;
    logic [CNT_W-1:0] taken;

    int n_err;
    int n_read;
    int n_cal;
    int n_ctr;

    initial
    begin
        dz_now    = '0;
        count_now = SAMPLE_COUNT_RST;
        ctr_x     = CENTER_RST;
        ctr_y     = CENTER_RST;
        acc_x     = '0;
        acc_y     = '0;
        taken     = '0;
        n_err     = 0;
        n_read    = 0;
        n_cal     = 0;
        n_ctr     = 0;
    end

    task automatic flag_error(string msg);
        if (n_err < 40)
        begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        n_err++;
    endtask

    // signed deflection of one axis around its center
    function automatic logic [AXIS_W-1:0] deflection(logic [RAW_W-1:0] raw,
                                                     logic [CTR_W-1:0] ctr,
                                                     logic [DZ_W-1:0]  dz);
        int d;
        int mag;
        int side;
        int room;
        int q;
        d   = int'(raw) - int'(ctr);
        mag = (d < 0) ? -d : d;
        if (mag <= int'(dz))
        begin
            return '0;
        end
        side = (d > 0) ? ADC_FULL_SCALE - int'(ctr) : int'(ctr);
        room = side - int'(dz);
        if (room <= 0)
        begin
            return '0;
        end
        q = (mag - int'(dz)) * 127 / room;
        if (q > 127)
        begin
            q = 127;
        end
        return (d < 0) ? AXIS_W'(-q) : AXIS_W'(q);
    endfunction

    task automatic accumulate(logic [RAW_W-1:0] rx, logic [RAW_W-1:0] ry);
        logic [CNT_W-1:0] need;
        logic [CNT_W:0]   n;
        need  = (count_now == '0) ? CNT_W'(1) : count_now;
        acc_x = acc_x + SUM_W'(rx);
        acc_y = acc_y + SUM_W'(ry);
        taken = taken + 1'b1;
        if (taken == '0 || taken >= need)
        begin
            n     = (taken == '0) ? {1'b1, {CNT_W{1'b0}}} : {1'b0, taken};
            ctr_x = CTR_W'(acc_x / n);
            ctr_y = CTR_W'(acc_y / n);
            acc_x = '0;
            acc_y = '0;
            taken = '0;
            n_ctr++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEADZONE:     dz_now    = cfg_data[DZ_W-1:0];
                    REG_SAMPLE_COUNT: count_now = cfg_data[CNT_W-1:0];
                    default:          flag_error("write to unknown register");
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_CAL)
                begin
                    accumulate(s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W]);
                    n_cal++;
                end
                else
                begin
                    want.ax  = deflection(s_tdata[RAW_W-1:0], ctr_x, dz_now);
                    want.ay  = deflection(s_tdata[2*RAW_W-1:RAW_W], ctr_y, dz_now);
                    want.tag = n_read;
                    deflections_due.push_back(want);
                    n_read++;
                end
            end
            if (m_tvalid && m_tready)
            begin
                if (deflections_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected output word %h", m_tdata));
                end
                else
                begin
                    want = deflections_due.pop_front();
                    if (m_tdata[AXIS_W-1:0] !== want.ax)
                    begin
                        flag_error($sformatf("read %0d axis_x got %0d want %0d", want.tag,
                                             $signed(m_tdata[AXIS_W-1:0]), $signed(want.ax)));
                    end
                    if (m_tdata[2*AXIS_W-1:AXIS_W] !== want.ay)
                    begin
                        flag_error($sformatf("read %0d axis_y got %0d want %0d", want.tag,
                                             $signed(m_tdata[2*AXIS_W-1:AXIS_W]),
                                             $signed(want.ay)));
                    end
                end
            end
        end
        errors      <= n_err;
        outstanding <= deflections_due.size();
        reads_seen  <= n_read;
        cals_seen   <= n_cal;
        centers_set <= n_ctr;
    end

endmodule

/* sim/joystick_deadzone_normalizer_tb.sv */
`timescale 1ns / 1ps

module joystick_deadzone_normalizer_tb;
    import jdn_pkg::*;

    localparam int RAND_PHASES    = 26;
    localparam int HOLD_PHASE     = 9;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 48;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [OP_W-1:0]       s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we;
    cfg_reg_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int outstanding;
    int reads_seen;
    int cals_seen;
    int centers_set;
    int quiet;
    int settings;
    bit calm;
    bit steady;
    bit hold_go;

    joystick_deadzone_normalizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    joystick_deadzone_normalizer_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .reads_seen  (reads_seen),
        .cals_seen   (cals_seen),
        .centers_set (centers_set)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        begin
            quiet <= 0;
        end
        else if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", quiet);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [RAW_W-1:0] clip12(int v);
        return (v < 0) ? '0 : (v > 4095) ? 12'd4095 : RAW_W'(v);
    endfunction

    // sample near the interesting points of one axis
    function automatic logic [RAW_W-1:0] aim(int c, int dz);
        int r;
        r = int'($urandom_range(0, 2));
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return 12'd4095;
            2:       return clip12(c + dz + r - 1);
            3:       return clip12(c - dz - r + 1);
            4:       return clip12(c + int'($urandom_range(0, 2 * dz + 2)) - dz - 1);
            default: return RAW_W'($urandom_range(0, 4095));
        endcase
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [RAW_W-1:0] x, logic [RAW_W-1:0] y);
        if (!calm && !steady && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {y, x};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // stop offering, let every read come back and any trailing average finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(int dz, int cnt);
        write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
        write_reg(REG_SAMPLE_COUNT, CFG_DATA_W'(cnt));
        cfg_we <= 1'b0;
        settings++;
    endtask

    initial
    begin
        m_tready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_go)
            begin
                hold_go = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    initial
    begin
        int dz;
        int cnt;
        int cx;
        int cy;
        int jit;
        int burst;
        int n_items;
        int kind;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_READ;
        cfg_we    <= 1'b0;
        cfg_index <= REG_DEADZONE;
        cfg_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset center, no dead zone
        steady = 1'b1;
        send_word(OP_READ, 12'd0, 12'd0);
        send_word(OP_READ, 12'd4095, 12'd4095);
        send_word(OP_READ, 12'd2047, 12'd2047);
        send_word(OP_READ, 12'd2048, 12'd2046);
        send_word(OP_READ, 12'd0, 12'd4095);
        settle();

        // count of zero averages a single sample, centers at both rails
        configure(100, 0);
        send_word(OP_CAL, 12'd0, 12'd4095);
        send_word(OP_READ, 12'd4095, 12'd0);
        send_word(OP_READ, 12'd0, 12'd4095);
        send_word(OP_READ, 12'd50, 12'd4000);
        send_word(OP_READ, 12'd101, 12'd3994);
        settle();

        // lower the count with samples already gathered
        configure(100, 64);
        repeat (5) send_word(OP_CAL, RAW_W'($urandom_range(0, 4095)),
                             RAW_W'($urandom_range(0, 4095)));
        settle();
        configure(100, 3);
        send_word(OP_CAL, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
        send_word(OP_READ, 12'd4095, 12'd0);
        send_word(OP_READ, RAW_W'($urandom_range(0, 4095)), RAW_W'($urandom_range(0, 4095)));
        settle();

        // widest dead zone
        configure(4095, 2);
        send_word(OP_CAL, 12'd4095, 12'd0);
        send_word(OP_CAL, 12'd0, 12'd4095);
        send_word(OP_READ, 12'd4095, 12'd0);
        send_word(OP_READ, 12'd0, 12'd4095);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            calm   = (p >= RAND_PHASES - 3);
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5))
                0:       dz = 0;
                1:       dz = 4095;
                2:       dz = int'($urandom_range(1, 30));
                3:       dz = int'($urandom_range(0, 400));
                4:       dz = int'($urandom_range(0, 4095));
                default: dz = int'($urandom_range(1500, 2100));
            endcase
            case ($urandom_range(0, 5))
                0:       cnt = 0;
                1:       cnt = 1;
                2:       cnt = 65535;
                default: cnt = int'($urandom_range(2, 12));
            endcase
            configure(dz, cnt);
            case ($urandom_range(0, 3))
                0:       cx = 0;
                1:       cx = 4095;
                default: cx = int'($urandom_range(0, 4095));
            endcase
            cy  = ($urandom_range(0, 3) == 0) ? 4095 - cx : int'($urandom_range(0, 4095));
            jit = int'($urandom_range(0, 40));

            // a full calibration run, or part of one for the huge count
            burst = (cnt == 0) ? 1 : (cnt > 16) ? 10 : cnt;
            for (int i = 0; i < burst; i++)
            begin
                send_word(OP_CAL, clip12(cx + int'($urandom_range(0, 2 * jit)) - jit),
                          clip12(cy + int'($urandom_range(0, 2 * jit)) - jit));
            end

            n_items = int'($urandom_range(45, 75));
            for (int i = 0; i < n_items; i++)
            begin
                kind = int'($urandom_range(0, 9));
                if (kind < 2)
                begin
                    send_word(OP_CAL, clip12(cx + int'($urandom_range(0, 2 * jit)) - jit),
                              clip12(cy + int'($urandom_range(0, 2 * jit)) - jit));
                end
                else if (kind < 8)
                begin
                    send_word(OP_READ, aim(cx, dz), aim(cy, dz));
                end
                else
                begin
                    send_word(OP_W'($urandom_range(0, 1)), RAW_W'($urandom_range(0, 4095)),
                              RAW_W'($urandom_range(0, 4095)));
                end
            end

            // receiver holds off while reads keep coming, so the input backs up
            if (p == HOLD_PHASE)
            begin
                hold_go = 1'b1;
                steady  = 1'b1;
                repeat (24) send_word(OP_READ, RAW_W'($urandom_range(0, 4095)),
                                      RAW_W'($urandom_range(0, 4095)));
            end
            settle();
        end

        $display("covered %0d reads and %0d calibration samples (%0d center updates)",
                 reads_seen, cals_seen, centers_set);
        $display("over %0d register settings, with a long output stall and drained pauses",
                 settings);
        if (errors == 0 && outstanding == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
